/* hdl/rtss_pkg.sv */
// rtss_pkg: shared types and constants for the record table substring search
// depends on nothing
`default_nettype none
package rtss_pkg;
    localparam int ENTRIES  = 16;
    localparam int NAME_LEN = 16;
    localparam int EW = $clog2(ENTRIES);
    localparam int PW = $clog2(NAME_LEN);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = $clog2(NAME_LEN + 1);
    localparam int AW = EW + PW;

    localparam logic [2:0] ACT_NAME    = 3'd0;
    localparam logic [2:0] ACT_PATTERN = 3'd1;
    localparam logic [2:0] ACT_SEARCH  = 3'd2;
    localparam logic [2:0] ACT_DELETE  = 3'd3;
    localparam logic [2:0] ACT_COUNT   = 3'd4;

    localparam logic [1:0] KIND_MATCH   = 2'd0;
    localparam logic [1:0] KIND_NOMATCH = 2'd1;
    localparam logic [1:0] KIND_DELETED = 2'd2;
    localparam logic [1:0] KIND_BAD     = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PLEN, ST_ENT, ST_NLEN, ST_CMP, ST_NEXT, ST_EMIT, ST_NOMATCH,
        ST_DRD, ST_DWR, ST_OUT
    } state_t;
endpackage
`default_nettype wire

/* hdl/record_table_substring_search.sv */
// record_table_substring_search: name table with naive substring search
// writes and set count act in the next cycle; delete moves each byte via ST_DRD then ST_DWR
// search: pattern length scan, then one pass over the table and, if any entry matched, a
// second; per entry up to NAME_LEN length reads plus (NAME_LEN/2)*(NAME_LEN/2+1) compare reads
// one request at a time; matches come out in the second pass, each held until taken
// reset (synchronous, aresetn low) clears count, pattern and control; names undefined
`default_nettype none
module record_table_substring_search import rtss_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[2:0], entry[7:3], position[11:8], char_value[19:12], zero pad
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // match_index[3:0], remaining_count[8:4], zero pad
    output logic [15:0]      m_tdata,
    // kind[1:0]
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    // name memory, one byte per address, registered read
    logic [7:0] name_mem [ENTRIES*NAME_LEN];
    logic [7:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) name_mem[wr_addr] <= wr_data;
        rd_data <= name_mem[rd_addr];
    end

    logic [7:0] pat_reg [NAME_LEN];
    logic [CW-1:0] count_reg;
    state_t state_reg, state_next;
    logic [EW:0] ent_reg, ent_next;           // current entry (wide to hold ENTRIES)
    logic [LW-1:0] cnt_reg, cnt_next;         // scan position / length counter
    logic [LW-1:0] plen_reg, plen_next, nlen_reg, nlen_next;
    logic [LW-1:0] off_reg, off_next, k_reg, k_next;
    logic [EW:0] lastm_reg, lastm_next;       // last matching entry, ENTRIES if none yet
    logic pass_reg, pass_next;                // second pass emits results
    logic [4:0] d_entry_reg, d_entry_next;
    logic [1:0] okind_reg, okind_next;
    logic [3:0] oidx_reg, oidx_next;
    logic olast_reg, olast_next;
    logic ovalid_reg, ovalid_next;

    logic acc;
    logic [2:0] in_action;
    logic [4:0] in_entry;
    logic [3:0] in_pos;
    logic [7:0] in_char;
    assign in_action = s_tdata[2:0];
    assign in_entry  = s_tdata[7:3];
    assign in_pos    = s_tdata[11:8];
    assign in_char   = s_tdata[19:12];
    assign s_tready  = aresetn && (state_reg == ST_IDLE) && !ovalid_reg;
    assign acc       = s_tvalid && s_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {7'd0, 5'(count_reg), oidx_reg};
    assign m_tuser  = okind_reg;

    logic [LW:0] sum_ok;
    logic [7:0]  pat_k;
    assign sum_ok = {1'b0, off_reg} + {1'b0, plen_reg};
    assign pat_k  = pat_reg[k_reg[PW-1:0]];

    always_comb begin
        state_next = state_reg;
        ent_next = ent_reg; cnt_next = cnt_reg; plen_next = plen_reg;
        nlen_next = nlen_reg; off_next = off_reg; k_next = k_reg;
        lastm_next = lastm_reg; pass_next = pass_reg; d_entry_next = d_entry_reg;
        okind_next = okind_reg; oidx_next = oidx_reg; olast_next = olast_reg;
        ovalid_next = ovalid_reg && !m_tready;
        rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = in_char;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    case (in_action)
                        ACT_NAME: begin
                            wr_en = (in_entry < 5'(ENTRIES)) && ({1'b0, in_pos} < 5'(NAME_LEN));
                            wr_addr = {in_entry[EW-1:0], in_pos[PW-1:0]};
                        end
                        ACT_SEARCH: begin
                            cnt_next = '0; state_next = ST_PLEN;
                            pass_next = 1'b0; lastm_next = (EW+1)'(ENTRIES);
                        end
                        ACT_DELETE: begin
                            d_entry_next = in_entry;
                            if ({1'b0, in_entry} >= 6'(count_reg)) begin
                                okind_next = KIND_BAD; oidx_next = '0; olast_next = 1'b1;
                                ovalid_next = 1'b1;
                            end else begin
                                ent_next = in_entry[EW:0]; cnt_next = '0;
                                state_next = ST_DRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PLEN: begin
                if (cnt_reg < LW'(NAME_LEN) && pat_reg[cnt_reg[PW-1:0]] != 8'd0)
                    cnt_next = cnt_reg + 1'b1;
                else begin
                    plen_next = cnt_reg; ent_next = '0; state_next = ST_ENT;
                end
            end
            ST_ENT: begin
                // start next entry or finish pass
                if ({1'b0, ent_reg} >= (EW+2)'(count_reg)) begin
                    if (!pass_reg) begin
                        if (lastm_reg == (EW+1)'(ENTRIES)) state_next = ST_NOMATCH;
                        else begin pass_next = 1'b1; ent_next = '0; end
                    end else state_next = ST_IDLE;
                end else begin
                    cnt_next = '0; rd_addr = {ent_reg[EW-1:0], {PW{1'b0}}};
                    state_next = ST_NLEN;
                end
            end
            ST_NLEN: begin
                // rd_data is byte cnt_reg
                if (rd_data != 8'd0) begin
                    cnt_next = cnt_reg + 1'b1;
                    rd_addr = {ent_reg[EW-1:0], cnt_next[PW-1:0]};
                end
                if (rd_data == 8'd0 || cnt_reg == LW'(NAME_LEN - 1)) begin
                    nlen_next = (rd_data == 8'd0) ? cnt_reg : LW'(NAME_LEN);
                    off_next = '0; k_next = '0;
                    if (plen_reg == '0) state_next = ST_EMIT;
                    else if (plen_reg > nlen_next) state_next = ST_NEXT;
                    else begin
                        rd_addr = {ent_reg[EW-1:0], {PW{1'b0}}};
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                // rd_data is name[off+k]
                if (rd_data != pat_k) begin
                    if ({1'b0, off_reg} + {1'b0, plen_reg} + 1'b1 > {1'b0, nlen_reg})
                        state_next = ST_NEXT;
                    else begin
                        off_next = off_reg + 1'b1; k_next = '0;
                        rd_addr = {ent_reg[EW-1:0], off_next[PW-1:0]};
                    end
                end else if (k_reg + 1'b1 == plen_reg) state_next = ST_EMIT;
                else begin
                    k_next = k_reg + 1'b1;
                    rd_addr = PW'(off_reg + k_next) | {ent_reg[EW-1:0], {PW{1'b0}}};
                end
                if (sum_ok == '0) state_next = ST_NEXT;
            end
            ST_EMIT: begin
                if (!pass_reg) begin
                    lastm_next = ent_reg; state_next = ST_NEXT;
                end else if (!ovalid_reg || m_tready) begin
                    okind_next = KIND_MATCH; oidx_next = 4'(ent_reg);
                    olast_next = (ent_reg == lastm_reg); ovalid_next = 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                ent_next = ent_reg + 1'b1; state_next = ST_ENT;
            end
            ST_NOMATCH: begin
                okind_next = KIND_NOMATCH; oidx_next = '0; olast_next = 1'b1;
                ovalid_next = 1'b1; state_next = ST_IDLE;
            end
            ST_DRD: begin
                // copy entry ent+1 into ent, byte by byte
                if ({1'b0, ent_reg} + 1'b1 >= (EW+2)'(count_reg)) state_next = ST_OUT;
                else begin
                    rd_addr = {4'(ent_reg + 1'b1), cnt_reg[PW-1:0]};
                    state_next = ST_DWR;
                end
            end
            ST_DWR: begin
                wr_en = 1'b1; wr_data = rd_data;
                wr_addr = {ent_reg[EW-1:0], cnt_reg[PW-1:0]};
                state_next = ST_DRD;
                if (cnt_reg == LW'(NAME_LEN - 1)) begin
                    cnt_next = '0; ent_next = ent_reg + 1'b1;
                end else cnt_next = cnt_reg + 1'b1;
            end
            ST_OUT: begin
                okind_next = KIND_DELETED; oidx_next = d_entry_reg[3:0];
                olast_next = 1'b1; ovalid_next = 1'b1; state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; ovalid_reg <= 1'b0; count_reg <= '0;
            for (int i = 0; i < NAME_LEN; i++) pat_reg[i] <= 8'd0;
        end else begin
            state_reg <= state_next; ovalid_reg <= ovalid_next;
            if (acc && in_action == ACT_PATTERN) pat_reg[in_pos[PW-1:0]] <= in_char;
            if (acc && in_action == ACT_COUNT)
                count_reg <= (in_entry > 5'(ENTRIES)) ? CW'(ENTRIES) : CW'(in_entry);
            if (state_reg == ST_OUT) count_reg <= count_reg - 1'b1;
        end
        ent_reg <= ent_next; cnt_reg <= cnt_next; plen_reg <= plen_next;
        nlen_reg <= nlen_next; off_reg <= off_next; k_reg <= k_next;
        lastm_reg <= lastm_next; pass_reg <= pass_next; d_entry_reg <= d_entry_next;
        okind_reg <= okind_next; oidx_reg <= oidx_next; olast_reg <= olast_next;
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast)) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready) else $error("request taken while busy");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(ENTRIES)) else $error("count overflow");
endmodule
`default_nettype wire
